// ===== rtl/core/masked_mean_stddev_assert.svh =====
// Assertion macros for the checker file of masked_mean_stddev.
`ifndef MASKED_MEAN_STDDEV_ASSERT_SVH
`define MASKED_MEAN_STDDEV_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("masked_mean_stddev: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("masked_mean_stddev: next-cycle check failed");

`endif

// ===== rtl/core/mms_pkg.sv =====
// Shared types and constants of the masked mean and standard deviation block.
package mms_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SQ_MAG_W  = 30;   // a squared sample is at most 2^30
    localparam int MEAN_W    = 24;
    localparam int STD_W     = 24;
    localparam int CNT_OUT_W = 17;
    localparam int FRAC_W    = 8;
    localparam int MEAN_QB   = 24;   // quotient bits of the mean division
    localparam int VAR_QB    = 46;   // quotient bits of the variance division
    localparam int VAR_SH    = 16;   // variance scaling, 2^16 for Q.8 after the root
    localparam int VAR_LOW_W = VAR_QB - VAR_SH;
    localparam int ROOT_W    = 23;
    localparam int STEP_W    = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MDIV,
        S_NSQ,
        S_NQ,
        S_SSQ,
        S_VDIV,
        S_ROOT,
        S_DONE
    } t_seq_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [STD_W-1:0]         std_q8;
        logic [CNT_OUT_W-1:0]     used_count;
        logic                     empty_set;
    } t_result;

endpackage

// ===== rtl/core/masked_mean_stddev.sv =====
// Top level: masked running mean and population standard deviation in Q.8.
// Unmasked items, the last too, go one per cycle while ready into the sum, sum of squares and count.
// An item marked last starts the sequencer; the result register loads after its mean divide,
// products, variance divide and root, and an empty set skips these steps.
// The input is not ready while the shared adder works through the divides, products and root.
// Synchronous active-low reset clears the accumulators, the sequencer and the output valid.
module masked_mean_stddev #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [mms_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                  i_masked,
    input  logic                                  i_is_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mms_pkg::MEAN_W-1:0]     o_mean_q8,
    output logic [mms_pkg::STD_W-1:0]             o_std_q8,
    output logic [mms_pkg::CNT_OUT_W-1:0]         o_used_count,
    output logic                                  o_empty_set
);
    import mms_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int SW = SAMPLE_W + CW;
    localparam int QW = SQ_MAG_W + CW;

    logic signed [SW-1:0] r_sum, n_sum;
    logic [QW-1:0]        r_sumsq, n_sumsq;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid;
    t_result              r_out;

    logic signed [2*SAMPLE_W-1:0] w_sq;
    logic    w_accept, w_take, w_busy, w_res_valid, w_res_ready;
    t_result w_res;

    assign w_accept = i_valid && o_ready;
    assign w_take   = w_accept && !i_masked && (r_count < CW'(MAX_SAMPLES));
    assign w_sq     = i_sample * i_sample;

    assign n_sum   = w_take ? r_sum + SW'(i_sample) : r_sum;
    assign n_sumsq = w_take ? r_sumsq + QW'(w_sq[SQ_MAG_W:0]) : r_sumsq;
    assign n_count = r_count + CW'(w_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_sumsq <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            if (i_is_last) begin
                r_sum   <= '0;
                r_sumsq <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_sumsq <= n_sumsq;
                r_count <= n_count;
            end
        end
    end

    mms_seq #(.CW(CW)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && i_is_last),
        .i_sum       (n_sum),
        .i_sumsq     (n_sumsq),
        .i_count     (n_count),
        .i_res_ready (w_res_ready),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // The output register takes a result when it is empty or its result is taken, which frees the sequencer.
    assign w_res_ready = !r_out_valid || i_ready;
    assign o_ready     = !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mean_q8    = r_out.mean_q8;
    assign o_std_q8     = r_out.std_q8;
    assign o_used_count = r_out.used_count;
    assign o_empty_set  = r_out.empty_set;

endmodule

// ===== rtl/core/mms_alu.sv =====
// Shared add/subtract unit with borrow flag, used by every step of the sequencer.
module mms_alu #(
    parameter int W = 66
) (
    input  mms_pkg::t_alu_op i_op,
    input  logic [W-1:0]     i_a,
    input  logic [W-1:0]     i_b,
    output logic [W-1:0]     o_res,
    output logic             o_borrow
);
    import mms_pkg::*;

    logic [W:0] w_full;

    always_comb begin
        unique case (i_op)
            ALU_ADD: w_full = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_full = {1'b0, i_a} - {1'b0, i_b};
            default: w_full = {1'b0, i_a};
        endcase
    end

    assign o_res    = w_full[W-1:0];
    assign o_borrow = (i_op == ALU_SUB) && w_full[W];

endmodule

// ===== rtl/core/mms_seq.sv =====
// Sequencer that turns the closed sums into mean and standard deviation on one shared adder.
module mms_seq #(
    parameter int CW = 17
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mms_pkg::SAMPLE_W+CW-1:0] i_sum,
    input  logic [mms_pkg::SQ_MAG_W+CW-1:0]     i_sumsq,
    input  logic [CW-1:0]                       i_count,
    input  logic                                i_res_ready,
    output logic                                o_busy,
    output logic                                o_res_valid,
    output mms_pkg::t_result                    o_res
);
    import mms_pkg::*;

    localparam int SW = SAMPLE_W + CW;
    localparam int QW = SQ_MAG_W + CW;
    localparam int AW = 2 * SW;

    t_seq_state r_state, n_state;
    logic [CW-1:0]     r_n, n_n;
    logic              r_sneg, n_sneg;
    logic [SW-1:0]     r_smag, n_smag;
    logic [QW-1:0]     r_q, n_q;
    logic [AW-1:0]     r_acc, n_acc;
    logic [AW-1:0]     r_mc, n_mc;
    logic [SW-1:0]     r_mp, n_mp;
    logic [VAR_QB-1:0] r_sh, n_sh;
    logic [VAR_QB-1:0] r_quo, n_quo;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [2*CW-1:0]   r_nsq, n_nsq;
    logic [MEAN_QB-1:0] r_mean, n_mean;
    logic              r_empty, n_empty;

    t_alu_op           w_op;
    logic [AW-1:0]     w_a, w_b, w_res, w_madd, w_dsel;
    logic              w_borrow, w_last;
    logic signed [SW-1:0] w_sum_neg;
    logic [SW-1:0]     w_smag;
    logic [MEAN_W-1:0] w_mean_neg;
    logic [CNT_OUT_W+CW-1:0] w_n_ext;

    assign w_sum_neg = -i_sum;
    assign w_smag    = i_sum[SW-1] ? w_sum_neg : i_sum;

    mms_alu #(.W(AW)) u_alu (
        .i_op     (w_op),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_res    (w_res),
        .o_borrow (w_borrow)
    );

    // Operand routing for the shared adder.
    always_comb begin
        unique case (r_state)
            S_MDIV: begin
                w_op = ALU_SUB;
                w_a  = {r_acc[AW-2:0], r_sh[VAR_QB-1]};
                w_b  = {{(AW-CW){1'b0}}, r_n};
            end
            S_NSQ, S_NQ: begin
                w_op = ALU_ADD;
                w_a  = r_acc;
                w_b  = r_mc;
            end
            S_SSQ: begin
                w_op = ALU_SUB;
                w_a  = r_acc;
                w_b  = r_mc;
            end
            S_VDIV: begin
                w_op = ALU_SUB;
                w_a  = {r_acc[AW-2:0], r_sh[VAR_QB-1]};
                w_b  = {{(AW-2*CW){1'b0}}, r_nsq};
            end
            S_ROOT: begin
                w_op = ALU_SUB;
                w_a  = {r_acc[AW-3:0], r_sh[VAR_QB-1 -: 2]};
                w_b  = {{(AW-ROOT_W-2){1'b0}}, r_quo[ROOT_W-1:0], 2'b01};
            end
            default: begin
                w_op = ALU_ADD;
                w_a  = r_acc;
                w_b  = r_mc;
            end
        endcase
    end

    // Multiply steps only take the adder result when the multiplier bit is set;
    // divide and root steps keep the shifted remainder on a borrow.
    assign w_madd = r_mp[0] ? w_res : r_acc;
    assign w_dsel = w_borrow ? w_a : w_res;
    assign w_last = (r_cnt == STEP_W'(1));

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_sneg  = r_sneg;
        n_smag  = r_smag;
        n_q     = r_q;
        n_acc   = r_acc;
        n_mc    = r_mc;
        n_mp    = r_mp;
        n_sh    = r_sh;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_nsq   = r_nsq;
        n_mean  = r_mean;
        n_empty = r_empty;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_sneg  = i_sum[SW-1];
                    n_smag  = w_smag;
                    n_q     = i_sumsq;
                    n_empty = (i_count == '0);
                    n_acc   = {{(AW-CW){1'b0}}, w_smag[SW-1:SAMPLE_W]};
                    n_sh    = {w_smag[SAMPLE_W-1:0], {(VAR_QB-SAMPLE_W){1'b0}}};
                    n_quo   = '0;
                    n_cnt   = STEP_W'(MEAN_QB);
                    n_state = (i_count == '0) ? S_DONE : S_MDIV;
                end
            end
            S_MDIV: begin
                n_acc = w_dsel;
                n_quo = {r_quo[VAR_QB-2:0], !w_borrow};
                n_sh  = r_sh << 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_mean  = {r_quo[MEAN_QB-2:0], !w_borrow};
                    n_acc   = '0;
                    n_mc    = {{(AW-CW){1'b0}}, r_n};
                    n_mp    = {{(SW-CW){1'b0}}, r_n};
                    n_cnt   = STEP_W'(CW);
                    n_state = S_NSQ;
                end
            end
            S_NSQ: begin
                n_acc = w_madd;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_nsq   = w_madd[2*CW-1:0];
                    n_acc   = '0;
                    n_mc    = {{(AW-QW){1'b0}}, r_q};
                    n_mp    = {{(SW-CW){1'b0}}, r_n};
                    n_cnt   = STEP_W'(CW);
                    n_state = S_NQ;
                end
            end
            S_NQ: begin
                n_acc = w_madd;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_mc    = {{(AW-SW){1'b0}}, r_smag};
                    n_mp    = r_smag;
                    n_cnt   = STEP_W'(SW);
                    n_state = S_SSQ;
                end
            end
            S_SSQ: begin
                // Subtracting the partial products of S*S never drops below n*Q - S*S.
                n_acc = w_madd;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_acc   = w_madd >> VAR_LOW_W;
                    n_sh    = {w_madd[VAR_LOW_W-1:0], {VAR_SH{1'b0}}};
                    n_quo   = '0;
                    n_cnt   = STEP_W'(VAR_QB);
                    n_state = S_VDIV;
                end
            end
            S_VDIV: begin
                n_acc = w_dsel;
                n_quo = {r_quo[VAR_QB-2:0], !w_borrow};
                n_sh  = r_sh << 1;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_sh    = {r_quo[VAR_QB-2:0], !w_borrow};
                    n_acc   = '0;
                    n_quo   = '0;
                    n_cnt   = STEP_W'(ROOT_W);
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                n_acc = w_dsel;
                n_quo = {r_quo[VAR_QB-2:0], !w_borrow};
                n_sh  = r_sh << 2;
                n_cnt = r_cnt - STEP_W'(1);
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_sneg  <= n_sneg;
        r_smag  <= n_smag;
        r_q     <= n_q;
        r_acc   <= n_acc;
        r_mc    <= n_mc;
        r_mp    <= n_mp;
        r_sh    <= n_sh;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_nsq   <= n_nsq;
        r_mean  <= n_mean;
        r_empty <= n_empty;
    end

    assign w_mean_neg = ~r_mean + MEAN_W'(1);
    assign w_n_ext    = {{CNT_OUT_W{1'b0}}, r_n};

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.empty_set  = r_empty;
        o_res.used_count = r_empty ? '0 : w_n_ext[CNT_OUT_W-1:0];
        o_res.mean_q8    = r_empty ? '0 : (r_sneg ? w_mean_neg : r_mean);
        o_res.std_q8     = r_empty ? '0 : {{(STD_W-ROOT_W){1'b0}}, r_quo[ROOT_W-1:0]};
    end

endmodule

// ===== rtl/core/mms_chk.sv =====
// Port-level checker for masked_mean_stddev and its bind.
`include "masked_mean_stddev_assert.svh"

module mms_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                i_is_last,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [mms_pkg::MEAN_W-1:0]   o_mean_q8,
    input logic [mms_pkg::STD_W-1:0]           o_std_q8,
    input logic [mms_pkg::CNT_OUT_W-1:0]       o_used_count,
    input logic                                o_empty_set
);

    // A stalled result beat keeps its valid and payload.
    `MMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_mean_q8) && $stable(o_std_q8) && $stable(o_used_count) && $stable(o_empty_set))

    // An empty set reports all-zero statistics.
    `MMS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_valid && o_empty_set, o_mean_q8 == '0 && o_std_q8 == '0 && o_used_count == '0)

    // A nonzero count never comes with the empty flag.
    `MMS_ASSERT_NOW(a_count_nonempty, i_clk, i_rst_n, o_valid && o_used_count != '0, !o_empty_set)

    // Closing a set keeps the sequencer busy, so the input is not ready in the cycle after.
    `MMS_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, i_valid && o_ready && i_is_last, !o_ready)

endmodule

bind masked_mean_stddev mms_chk u_mms_chk (.*);
